// File: src/glu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package glu_pkg;

  localparam int DATA_W      = 16;
  localparam int MULT_W      = 32;
  localparam int SHIFT_W     = $clog2(DATA_W);
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [DATA_W-1:0] first_value;
    logic [DATA_W-1:0] second_value;
  } glu_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] common_divisor;
    logic [MULT_W-1:0] common_multiple;
  } glu_out_t;

  // one classified beat waiting for the back end
  typedef struct packed {
    logic              zero_case;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } glu_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } glu_q_status_t;

endpackage
`default_nettype wire

// File: src/glu_front.sv
`timescale 1ns / 1ps
`default_nettype none
module glu_front
  import glu_pkg::*;
#(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire logic          start,
  input  wire glu_in_t       operands,
  input  wire glu_q_status_t q_stat,
  output logic               push,
  output glu_entry_t         entry
);

  localparam int KEEP_W = (OPERAND_WIDTH < DATA_W) ? OPERAND_WIDTH : DATA_W;
  localparam logic [DATA_W:0] ONE_EXT  = (DATA_W+1)'(1);
  localparam logic [DATA_W:0] MASK_EXT = (ONE_EXT << KEEP_W) - ONE_EXT;
  localparam logic [DATA_W-1:0] OP_MASK = MASK_EXT[DATA_W-1:0];

  // take a beat whenever the queue has room
  assign push = start && !q_stat.full;

  // drop bits above the operand width and flag a zero operand
  always_comb begin
    entry.a         = operands.first_value & OP_MASK;
    entry.b         = operands.second_value & OP_MASK;
    entry.zero_case = (entry.a == '0) || (entry.b == '0);
  end

endmodule
`default_nettype wire

// File: src/glu_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module glu_queue
  import glu_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire glu_entry_t    wr_entry,
  input  wire logic          pop,
  output glu_entry_t         rd_entry,
  output glu_q_status_t      q_stat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

  glu_entry_t       slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign rd_entry     = slots[rd_ptr];
  assign q_stat.full  = (count == DEPTH_CNT);
  assign q_stat.empty = (count == '0);

  // store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  // advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: src/glu_back.sv
`timescale 1ns / 1ps
`default_nettype none
module glu_back
  import glu_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire glu_q_status_t q_stat,
  input  wire glu_entry_t    entry,
  output logic               pop,
  output logic               done,
  output glu_out_t           result
);

  localparam logic [SHIFT_W-1:0] LAST_BIT = SHIFT_W'(DATA_W - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV,
    ST_MUL
  } state_t;

  state_t             state;
  logic [DATA_W-1:0]  u;
  logic [DATA_W-1:0]  v;
  logic [SHIFT_W-1:0] k;
  logic [DATA_W-1:0]  a0;
  logic [DATA_W-1:0]  b0;
  logic [DATA_W-1:0]  g;
  logic [DATA_W-1:0]  rem;
  logic [DATA_W-1:0]  quo;
  logic [SHIFT_W-1:0] cnt;

  logic [DATA_W-1:0]  u_next;
  logic [DATA_W-1:0]  v_next;
  logic [SHIFT_W-1:0] k_next;
  logic [DATA_W:0]    trial;
  logic               fits;
  logic [DATA_W:0]    trial_diff;

  assign pop = (state == ST_IDLE) && !q_stat.empty;

  // one binary GCD step: pull out common twos, strip lone twos, subtract odd pairs
  always_comb begin
    u_next = u;
    v_next = v;
    k_next = k;
    if (!u[0] && !v[0]) begin
      u_next = u >> 1;
      v_next = v >> 1;
      k_next = k + SHIFT_W'(1);
    end else if (!u[0]) begin
      u_next = u >> 1;
    end else if (!v[0]) begin
      v_next = v >> 1;
    end else if (u > v) begin
      u_next = (u - v) >> 1;
    end else begin
      v_next = (v - u) >> 1;
    end
  end

  // one restoring divide step of a0 by g
  always_comb begin
    trial      = {rem, quo[DATA_W-1]};
    fits       = (trial >= {1'b0, g});
    trial_diff = trial - {1'b0, g};
  end

  // hold state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            if (entry.zero_case) begin
              result.common_divisor  <= entry.a | entry.b;
              result.common_multiple <= '0;
              done                   <= 1'b1;
            end else begin
              u     <= entry.a;
              v     <= entry.b;
              a0    <= entry.a;
              b0    <= entry.b;
              k     <= '0;
              state <= ST_GCD;
            end
          end
        end
        ST_GCD: begin
          if (u == v) begin
            g     <= u << k;
            rem   <= '0;
            quo   <= a0;
            cnt   <= '0;
            state <= ST_DIV;
          end else begin
            u <= u_next;
            v <= v_next;
            k <= k_next;
          end
        end
        ST_DIV: begin
          rem <= fits ? trial_diff[DATA_W-1:0] : trial[DATA_W-1:0];
          quo <= {quo[DATA_W-2:0], fits};
          cnt <= cnt + SHIFT_W'(1);
          if (cnt == LAST_BIT) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          result.common_divisor  <= g;
          result.common_multiple <= MULT_W'(quo) * MULT_W'(b0);
          done                   <= 1'b1;
          state                  <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: src/gcd_lcm_unit.sv
// Flow: an accepted beat is written into the queue and popped by the back end once it is idle; when
//   an operand is zero the result is registered directly, else GCD steps run until u equals v, then
//   one restoring divide step per quotient bit and a multiply. Throughput: one pair per back-end pass,
//   set by the GCD step loop and the bit-serial divider; a two-entry queue takes beats meanwhile.
// Results appear for one cycle on done; the receiver cannot stall.
// Reset (rst, synchronous) empties the queue and returns the back end to idle.
`timescale 1ns / 1ps
`default_nettype none
module gcd_lcm_unit
  import glu_pkg::*;
#(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire glu_in_t operands,
  output logic         busy,
  output logic         done,
  output glu_out_t     result
);

  logic          push;
  logic          pop;
  glu_entry_t    wr_entry;
  glu_entry_t    rd_entry;
  glu_q_status_t q_stat;

  assign busy = q_stat.full;

  glu_front #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_front (
    .start   (start),
    .operands(operands),
    .q_stat  (q_stat),
    .push    (push),
    .entry   (wr_entry)
  );

  glu_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_entry(wr_entry),
    .pop     (pop),
    .rd_entry(rd_entry),
    .q_stat  (q_stat)
  );

  glu_back u_back (
    .clk   (clk),
    .rst   (rst),
    .q_stat(q_stat),
    .entry (rd_entry),
    .pop   (pop),
    .done  (done),
    .result(result)
  );

`ifndef SYNTHESIS
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("push into a full queue");

  a_pop_has_data: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("pop from an empty queue");

  a_status_sane: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  a_pop_then_idle_push: assert property (@(posedge clk) disable iff (rst)
    (q_stat.empty && !push) |=> !pop)
    else $error("back end popped an entry that was never written");
`endif

endmodule
`default_nettype wire
